/* src/tos_pkg.sv */
package tos_pkg;

    localparam logic [7:0] BYTE_IAC = 8'd255;
    localparam logic [7:0] BYTE_CR  = 8'd13;
    localparam logic [7:0] BYTE_LF  = 8'd10;
    localparam logic [7:0] BYTE_NUL = 8'd0;

    // most bytes one input byte can cause
    localparam int unsigned MAX_RESULTS = 3;

    // encoded bytes of one input byte and the slot of its final byte
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  last_idx;
    } t_plan;

endpackage

/* src/tos_encoder.sv */
module tos_encoder (
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_burst,
    input  logic          i_cr_pending,
    input  logic          i_binary_mode,
    output tos_pkg::t_plan o_plan,
    output logic          o_cr_pending
);

    logic       w_pad_first;
    logic       w_double;
    logic       w_cr_normal;
    logic       w_pad_after;
    logic [7:0] w_tail;

    // classify the byte against the pending cr and the mode
    assign w_pad_first = i_cr_pending && (i_data_byte != tos_pkg::BYTE_LF);
    assign w_double    = (i_data_byte == tos_pkg::BYTE_IAC);
    assign w_cr_normal = (i_data_byte == tos_pkg::BYTE_CR) && !i_binary_mode;
    assign w_pad_after = w_cr_normal && i_end_of_burst;
    assign w_tail      = w_double ? tos_pkg::BYTE_IAC : tos_pkg::BYTE_NUL;

    // a cr in normal mode without end of burst waits for the next byte
    assign o_cr_pending = w_cr_normal && !i_end_of_burst;

    // lay out the byte sequence: optional zero, the byte, optional tail
    always_comb begin
        o_plan.bytes[0]  = w_pad_first ? tos_pkg::BYTE_NUL : i_data_byte;
        o_plan.bytes[1]  = w_pad_first ? i_data_byte : w_tail;
        o_plan.bytes[2]  = w_tail;
        o_plan.last_idx  = {1'b0, w_pad_first} + {1'b0, (w_double || w_pad_after)};
    end

endmodule

/* src/tos_emitter.sv */
module tos_emitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load_valid,
    input  tos_pkg::t_plan i_load_plan,
    output logic           o_load_ready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,
    output logic           o_m_tlast
);

    logic           r_valid;
    tos_pkg::t_plan r_plan;
    logic [1:0]     r_idx;
    logic           w_beat;
    logic           w_last;

    assign w_last       = (r_idx == r_plan.last_idx);
    assign w_beat       = r_valid && i_m_tready;
    assign o_load_ready = !r_valid || (w_beat && w_last);

    // present the current slot of the held plan
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_plan.bytes[r_idx];
    assign o_m_tlast  = w_last;

    // step through the plan, load the next one as the last byte leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_load_ready) begin
            r_valid <= i_load_valid;
            r_idx   <= 2'd0;
            if (i_load_valid) begin
                r_plan <= i_load_plan;
            end
        end else if (w_beat) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

/* src/telnet_output_byte_stuffer_top.sv */
// an accepted request is held in the input register, then in the emitter, before it leaves
// throughput: one input byte per cycle while the receiver is ready and each byte encodes to one output byte
// a byte that is doubled or padded holds the output until each of its encoded bytes has left
// the rate is set by the single output port of the emitter stage
// reset (synchronous, active low) clears the pending cr, binary mode and both stages
module telnet_output_byte_stuffer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // end_of_burst
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // last_of_run
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data   // binary_mode
);

    logic           r_binary_mode;
    logic           r_cr_pending;
    logic           r_s1_valid;
    tos_pkg::t_plan r_s1_plan;
    tos_pkg::t_plan w_plan;
    logic           w_next_pending;
    logic           w_s1_take;
    logic           w_accept;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_binary_mode <= i_cfg_data;
        end
    end

    // encode the incoming byte against the pending cr
    tos_encoder u_encoder (
        .i_data_byte    (i_s_tdata),
        .i_end_of_burst (i_s_tlast),
        .i_cr_pending   (r_cr_pending),
        .i_binary_mode  (r_binary_mode),
        .o_plan         (w_plan),
        .o_cr_pending   (w_next_pending)
    );

    assign o_s_tready = !r_s1_valid || w_s1_take;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // input register holding one encoded request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_cr_pending <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid   <= 1'b1;
            r_s1_plan    <= w_plan;
            r_cr_pending <= w_next_pending;
        end else if (w_s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    // result stage sending the encoded bytes one per cycle while the receiver is ready
    tos_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_s1_valid),
        .i_load_plan  (r_s1_plan),
        .o_load_ready (w_s1_take),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast)
    );

endmodule

/* src/tos_checker.sv */
module tos_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    logic [1:0] r_inflight;
    logic [1:0] r_run;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_out_done;

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_acc  = o_m_tvalid && i_m_tready;
    assign w_out_done = w_out_acc && o_m_tlast;

    // requests accepted whose final byte has not left yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 2'd0;
            r_run      <= 2'd0;
        end else begin
            r_inflight <= r_inflight + {1'b0, w_in_acc} - {1'b0, w_out_done};
            if (w_out_done) begin
                r_run <= 2'd0;
            end else if (w_out_acc) begin
                r_run <= r_run + 2'd1;
            end
        end
    end

    // no more than the two stages can hold
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight != 2'd3)
        else $error("more requests in flight than stages");

    // an output byte always belongs to an accepted request
    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_inflight != 2'd0)
        else $error("output byte without an accepted request");

    // at most three bytes per request
    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_run == 2'd2) |-> o_m_tlast)
        else $error("request produced more than three bytes");

    // a stalled output byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled output changed");

endmodule

bind telnet_output_byte_stuffer_top tos_checker u_tos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast)
);

/* tb/sv/tb_telnet_output_byte_stuffer_top.sv */
module tb_telnet_output_byte_stuffer_top;

    localparam logic MODE_NORMAL = 1'b0;
    localparam logic MODE_BINARY = 1'b1;
    localparam int   N_ROWS      = 24;
    localparam int   N_PHASES    = 8;
    localparam int   PHASE_BYTES = 40;
    localparam int   LONG_HOLD   = 48;
    localparam int   TAIL_CYCLES = 8;

    // mode change done before a directed row
    typedef enum logic [1:0] {CFG_KEEP, CFG_NORMAL, CFG_BINARY} t_mode_op;

    typedef struct packed {
        logic [7:0] octet;
        logic       last_flag;
    } t_net_byte;

    // directed row: n_want of 0 leaves the result to the encoder model
    typedef struct {
        t_mode_op   op;
        logic [7:0] data;
        logic       eob;
        int         n_want;
        logic [7:0] want [3];
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] data_byte
    logic       i_s_tlast;   // end_of_burst
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [7:0] out_byte
    logic       o_m_tlast;   // last_of_run
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;  // binary_mode

    // encoder model state
    logic       bin_mode = MODE_NORMAL;
    logic       pad_due  = 1'b0;
    t_net_byte  net_q [$];

    // run control and statistics
    bit         tx_gaps     = 1'b1;
    bit         rx_gaps     = 1'b1;
    int         rx_hold_len = 0;
    int         err_count   = 0;
    int         n_bytes_in  = 0;
    int         n_bytes_out = 0;
    int         n_mode_wr   = 0;
    int         n_pads      = 0;
    int         n_iac_dbl   = 0;
    logic [7:0] no_typed [3] = '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL};

    t_row plan_tbl [N_ROWS] = '{
        '{CFG_KEEP,   tos_pkg::BYTE_NUL, 1'b0, 1,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_IAC, 1'b0, 2,
          '{tos_pkg::BYTE_IAC, tos_pkg::BYTE_IAC, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   8'h41,             1'b1, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b0, 1,
          '{tos_pkg::BYTE_CR,  tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_LF,  1'b0, 1,
          '{tos_pkg::BYTE_LF,  tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   8'h42,             1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b1, 2,
          '{tos_pkg::BYTE_CR,  tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_IAC, 1'b0, 3,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_IAC, tos_pkg::BYTE_IAC}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b1, 3,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_CR,  tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_BINARY, 8'h43,             1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b0, 1,
          '{tos_pkg::BYTE_CR,  tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_CR,  1'b1, 1,
          '{tos_pkg::BYTE_CR,  tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_IAC, 1'b1, 2,
          '{tos_pkg::BYTE_IAC, tos_pkg::BYTE_IAC, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   tos_pkg::BYTE_LF,  1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_NORMAL, tos_pkg::BYTE_CR,  1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_BINARY, tos_pkg::BYTE_LF,  1'b1, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_NORMAL, 8'h80,             1'b1, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   8'h7F,             1'b0, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}},
        '{CFG_KEEP,   8'hFE,             1'b1, 0,
          '{tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL, tos_pkg::BYTE_NUL}}
    };

    telnet_output_byte_stuffer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // clock, period 8
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // network bytes that one terminal byte turns into
    function automatic void encode_byte(input logic [7:0] b, input logic eob,
                                        output t_net_byte res [3], output int n);
        n = 0;
        // a pending cr is resolved by this byte, whatever the mode is now
        if (pad_due) begin
            if (b != tos_pkg::BYTE_LF) begin
                res[n] = '{tos_pkg::BYTE_NUL, 1'b0};
                n++;
                n_pads++;
            end
            pad_due = 1'b0;
        end
        res[n] = '{b, 1'b0};
        n++;
        if (b == tos_pkg::BYTE_IAC) begin
            res[n] = '{tos_pkg::BYTE_IAC, 1'b0};
            n++;
            n_iac_dbl++;
        end else if (b == tos_pkg::BYTE_CR && bin_mode == MODE_NORMAL) begin
            if (eob) begin
                res[n] = '{tos_pkg::BYTE_NUL, 1'b0};
                n++;
                n_pads++;
            end else begin
                pad_due = 1'b1;
            end
        end
        res[n-1].last_flag = 1'b1;
    endfunction

    // offer one terminal byte and record what it should produce
    task automatic push_byte(input logic [7:0] b, input logic eob,
                             input int n_typed, input logic [7:0] typed [3]);
        t_net_byte res [3];
        int        n;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eob;
        do @(posedge i_clk); while (!o_s_tready);
        encode_byte(b, eob, res, n);
        if (n_typed != 0) begin
            for (int i = 0; i < n_typed; i++)
                net_q.push_back(t_net_byte'{typed[i], i == n_typed - 1});
        end else begin
            for (int i = 0; i < n; i++)
                net_q.push_back(res[i]);
        end
        n_bytes_in++;
    endtask

    // stop offering and wait for every expected network byte
    task automatic drain_stream();
        i_s_tvalid <= 1'b0;
        while (net_q.size() != 0) @(posedge i_clk);
    endtask

    // binary_mode write, only with the block idle
    task automatic write_mode(input logic mode);
        drain_stream();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bin_mode = mode;
        n_mode_wr++;
    endtask

    // receiver: random stalls plus one long hold on request
    initial begin : rx_side
        int hold;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_len != 0) begin
                hold = rx_hold_len;
                rx_hold_len = 0;
                i_m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // compare each accepted network byte with the oldest expectation
    always @(posedge i_clk) begin : net_check
        t_net_byte want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_bytes_out++;
            if (net_q.size() == 0) begin
                $error("unexpected network byte %02h, last_of_run %0b", o_m_tdata, o_m_tlast);
                err_count++;
            end else begin
                want = net_q.pop_front();
                if (o_m_tdata !== want.octet) begin
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           want.octet, o_m_tdata);
                    err_count++;
                end
                if (o_m_tlast !== want.last_flag) begin
                    $error("last_of_run mismatch: expected %0b, actual %0b",
                           want.last_flag, o_m_tlast);
                    err_count++;
                end
            end
        end
    end

    // main sequence
    initial begin : main_seq
        logic [7:0] b;
        logic       eob;
        int         r;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= 8'h00;
        i_s_tlast   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (plan_tbl[k]) begin
            if (plan_tbl[k].op == CFG_NORMAL)
                write_mode(MODE_NORMAL);
            else if (plan_tbl[k].op == CFG_BINARY)
                write_mode(MODE_BINARY);
            push_byte(plan_tbl[k].data, plan_tbl[k].eob, plan_tbl[k].n_want,
                      plan_tbl[k].want);
        end

        // random phases, alternating mode; the last two run without idling
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_mode(ph % 2 == 0 ? MODE_BINARY : MODE_NORMAL);
            if (ph >= N_PHASES - 2) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            if (ph == 2)
                rx_hold_len = LONG_HOLD;
            for (int k = 0; k < PHASE_BYTES; k++) begin
                if (ph == 4 && k == PHASE_BYTES / 2)
                    drain_stream();
                // mostly cr, lf and iac so that pads and doublings stack up
                r = $urandom_range(0, 99);
                if (r < 22)
                    b = tos_pkg::BYTE_CR;
                else if (r < 38)
                    b = tos_pkg::BYTE_LF;
                else if (r < 52)
                    b = tos_pkg::BYTE_IAC;
                else if (r < 57)
                    b = tos_pkg::BYTE_NUL;
                else
                    b = 8'($urandom_range(0, 255));
                eob = ($urandom_range(0, 3) == 0);
                push_byte(b, eob, 0, no_typed);
            end
        end

        // wrap up
        drain_stream();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (net_q.size() != 0) begin
            $error("%0d network bytes never arrived", net_q.size());
            err_count++;
        end
        $display("covered %0d terminal bytes -> %0d network bytes, %0d mode writes",
                 n_bytes_in, n_bytes_out, n_mode_wr);
        $display("zero pads predicted: %0d, iac doublings predicted: %0d, errors: %0d",
                 n_pads, n_iac_dbl, err_count);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* telnet_output_byte_stuffer_top.f */
src/tos_pkg.sv
src/tos_encoder.sv
src/tos_emitter.sv
src/telnet_output_byte_stuffer_top.sv
src/tos_checker.sv
tb/sv/tb_telnet_output_byte_stuffer_top.sv
